>>> sv/i2cmbs_pkg.sv
// Package: item types, configuration and sequencer state types, bus step functions.
package i2cmbs_pkg;

	localparam int HalfWidth = 16;
	localparam int PollWidth = 8;
	localparam logic [HalfWidth-1:0] HalfReset = 16'd12;
	localparam logic [PollWidth-1:0] PollReset = 8'd250;

	typedef enum logic {
		CFG_HALF_PERIOD = 1'b0,
		CFG_ACK_POLL    = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_STOP  = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SA, PH_SB, PH_WL, PH_WH, PH_WE, PH_KR, PH_KH, PH_POLL,
		PH_RL, PH_RH, PH_AL, PH_AH, PH_PL, PH_PH, PH_PD
	} phase_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [6:0] target_address;
		logic       read_not_write;
		logic [7:0] write_byte;
		logic       last_byte;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_error;
		logic [7:0] read_data;
	} res_t;

	typedef struct packed {
		logic [HalfWidth-1:0] half_period_ticks;
		logic [PollWidth-1:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic [HalfWidth-1:0] tick_count;
		logic [3:0]           bit_index;
		logic [7:0]           shift_byte;
		logic [PollWidth-1:0] poll_count;
		logic                 scl;
		logic                 sda;
		logic                 oe;
		logic                 nack_pending;
		logic                 err;
		logic [7:0]           read_hold;
	} seq_state_t;

	function automatic seq_state_t drive_bus(seq_state_t s, logic en, logic scl, logic sda);
		seq_state_t r;
		r = s;
		r.oe = en;
		r.scl = scl;
		r.sda = en ? sda : 1'b1;
		return r;
	endfunction

	function automatic seq_state_t enter_phase(seq_state_t s, phase_t p, logic sda_in);
		seq_state_t r;
		r = s;
		r.phase = p;
		r.tick_count = HalfWidth'(1);
		case (p)
			PH_SA:   r = drive_bus(r, 1'b1, 1'b1, 1'b1);
			PH_SB:   r = drive_bus(r, 1'b1, 1'b1, 1'b0);
			PH_WL:   r = drive_bus(r, 1'b1, 1'b0, r.shift_byte[7]);
			PH_WH:   r = drive_bus(r, 1'b1, 1'b1, r.sda);
			PH_WE:   r = drive_bus(r, 1'b1, 1'b0, r.sda);
			PH_KR:   r = drive_bus(r, 1'b0, 1'b0, 1'b1);
			PH_KH:   r = drive_bus(r, 1'b0, 1'b1, 1'b1);
			PH_POLL: r.poll_count = '0;
			PH_RL:   r = drive_bus(r, 1'b0, 1'b0, 1'b1);
			PH_RH: begin
				r = drive_bus(r, 1'b0, 1'b1, 1'b1);
				r.shift_byte = {r.shift_byte[6:0], sda_in};
			end
			PH_AL:   r = drive_bus(r, 1'b1, 1'b0, r.nack_pending);
			PH_AH:   r = drive_bus(r, 1'b1, 1'b1, r.nack_pending);
			PH_PL:   r = drive_bus(r, 1'b1, 1'b0, 1'b0);
			PH_PH:   r = drive_bus(r, 1'b1, 1'b1, 1'b0);
			PH_PD:   r = drive_bus(r, 1'b1, 1'b1, 1'b1);
			default: r = r;
		endcase
		return r;
	endfunction

endpackage

>>> sv/i2cmbs_sequencer.sv
// Bus step sequencer: state registers and per-item next-state and result logic.
module i2cmbs_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2cmbs_pkg::cmd_t  cmd,
	input  i2cmbs_pkg::cfg_t  cfg,
	output i2cmbs_pkg::res_t  res
);
	import i2cmbs_pkg::*;

	seq_state_t state_q;
	seq_state_t n;
	logic done_n;
	logic err_n;
	logic [HalfWidth-1:0] half;
	logic [PollWidth-1:0] lim;

	assign half = (cfg.half_period_ticks == '0) ? HalfWidth'(1) : cfg.half_period_ticks;
	assign lim = (cfg.ack_poll_limit == '0) ? PollWidth'(1) : cfg.ack_poll_limit;

	always_comb begin
		n = state_q;
		done_n = 1'b0;
		err_n = 1'b0;
		if (state_q.phase == PH_IDLE) begin
			case (cmd.opcode)
				OP_START: begin
					n.shift_byte = {cmd.target_address, cmd.read_not_write};
					n.err = 1'b0;
					n = enter_phase(n, PH_SA, cmd.sda_in);
				end
				OP_WRITE: begin
					n.shift_byte = cmd.write_byte;
					n.bit_index = '0;
					n.err = 1'b0;
					n = enter_phase(n, PH_WL, cmd.sda_in);
				end
				OP_READ: begin
					n.shift_byte = '0;
					n.bit_index = '0;
					n.nack_pending = cmd.last_byte;
					n.err = 1'b0;
					n = enter_phase(n, PH_RL, cmd.sda_in);
				end
				OP_STOP: begin
					n.err = 1'b0;
					n = enter_phase(n, PH_PL, cmd.sda_in);
				end
				default: n = state_q;
			endcase
		end else if (state_q.phase == PH_POLL) begin
			if (!cmd.sda_in) begin
				n = drive_bus(n, 1'b0, 1'b0, 1'b1);
				n.phase = PH_IDLE;
				n.tick_count = '0;
				done_n = 1'b1;
				err_n = n.err;
				n.err = 1'b0;
			end else begin
				n.poll_count = state_q.poll_count + PollWidth'(1);
				if (n.poll_count >= lim) begin
					n.err = 1'b1;
					n = enter_phase(n, PH_PL, cmd.sda_in);
				end
			end
		end else if (state_q.tick_count >= half) begin
			case (state_q.phase)
				PH_SA: n = enter_phase(n, PH_SB, cmd.sda_in);
				PH_SB: begin
					n.bit_index = '0;
					n = enter_phase(n, PH_WL, cmd.sda_in);
				end
				PH_WL: n = enter_phase(n, PH_WH, cmd.sda_in);
				PH_WH: n = enter_phase(n, PH_WE, cmd.sda_in);
				PH_WE: begin
					n.shift_byte = {state_q.shift_byte[6:0], 1'b0};
					n.bit_index = state_q.bit_index + 4'd1;
					if (n.bit_index < 4'd8) begin
						n = enter_phase(n, PH_WL, cmd.sda_in);
					end else begin
						n = enter_phase(n, PH_KR, cmd.sda_in);
					end
				end
				PH_KR: n = enter_phase(n, PH_KH, cmd.sda_in);
				PH_KH: n = enter_phase(n, PH_POLL, cmd.sda_in);
				PH_RL: n = enter_phase(n, PH_RH, cmd.sda_in);
				PH_RH: begin
					n.bit_index = state_q.bit_index + 4'd1;
					if (n.bit_index < 4'd8) begin
						n = enter_phase(n, PH_RL, cmd.sda_in);
					end else begin
						n = enter_phase(n, PH_AL, cmd.sda_in);
					end
				end
				PH_AL: n = enter_phase(n, PH_AH, cmd.sda_in);
				PH_AH: begin
					n = drive_bus(n, 1'b1, 1'b0, state_q.sda);
					n.read_hold = state_q.shift_byte;
					n.phase = PH_IDLE;
					n.tick_count = '0;
					done_n = 1'b1;
					err_n = n.err;
					n.err = 1'b0;
				end
				PH_PL: n = enter_phase(n, PH_PH, cmd.sda_in);
				PH_PH: n = enter_phase(n, PH_PD, cmd.sda_in);
				default: begin
					n.phase = PH_IDLE;
					n.tick_count = '0;
					done_n = 1'b1;
					err_n = n.err;
					n.err = 1'b0;
				end
			endcase
		end else begin
			n.tick_count = state_q.tick_count + HalfWidth'(1);
		end
	end

	always_comb begin
		res.scl_level = n.scl;
		res.sda_level = n.sda;
		res.sda_drive = n.oe;
		res.busy_res = (n.phase != PH_IDLE);
		res.done_res = done_n;
		res.ack_error = err_n;
		res.read_data = n.read_hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.tick_count <= '0;
			state_q.bit_index <= '0;
			state_q.shift_byte <= '0;
			state_q.poll_count <= '0;
			state_q.scl <= 1'b1;
			state_q.sda <= 1'b1;
			state_q.oe <= 1'b1;
			state_q.nack_pending <= 1'b0;
			state_q.err <= 1'b0;
			state_q.read_hold <= '0;
		end else if (step) begin
			state_q <= n;
		end
	end

endmodule

>>> sv/i2c_master_byte_sequencer_top.sv
// Top level: I2C master byte sequencer with configuration registers and result buffer.
//
//  channel  signals                        direction  item
//  cmd      cmd_valid, cmd_stall, cmd      in         one bus tick, optional command
//  res      res_valid, res_stall, res      out        bus levels and status after the tick
//  cfg      cfg_valid, cfg_ready, cfg_*    in         register write, index 0 or 1
//
//  One cmd item is taken per cycle while cmd_stall is low; its result is registered.
//  A two-entry result buffer (output register plus skid) keeps cmd flowing while
//  res stalls; cmd_stall rises only when both entries are full.
//  Reset releases the bus high with SDA driven, configuration at 12 and 250.
//  cfg_ready is always high; writes take effect on the next item.
module i2c_master_byte_sequencer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  i2cmbs_pkg::cmd_t                      cmd,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output i2cmbs_pkg::res_t                      res,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  i2cmbs_pkg::cfg_index_t                cfg_index,
	input  logic [i2cmbs_pkg::HalfWidth-1:0]      cfg_data
);
	import i2cmbs_pkg::*;

	cfg_t cfg_q;
	res_t res_n;
	res_t main_q;
	res_t skid_q;
	logic main_valid_q;
	logic skid_valid_q;
	logic accept;
	logic take;

	assign cfg_ready = 1'b1;
	assign cmd_stall = skid_valid_q;
	assign accept = cmd_valid && !skid_valid_q;
	assign take = main_valid_q && !res_stall;
	assign res_valid = main_valid_q;
	assign res = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HalfReset;
			cfg_q.ack_poll_limit <= PollReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data;
				CFG_ACK_POLL:    cfg_q.ack_poll_limit <= cfg_data[PollWidth-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	i2cmbs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.res    (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (main_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (accept) begin
			if (main_valid_q && !take) begin
				skid_q <= res_n;
			end else begin
				main_q <= res_n;
			end
		end
	end

endmodule
